[rtl/core/rrtns_pkg.sv]
// shared constants and types for the rrt nearest-point and steer core
package rrtns_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int COORD_BITS  = 16;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_BITS    = 10;
  localparam int EXT_BITS    = 15;
  localparam int STEP_BITS   = 17;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS + 1;
  localparam int MUL_BITS   = DIFF_BITS + 1;
  localparam int PROD_BITS  = 2 * MUL_BITS;
  localparam int SQRT_IN_BITS = 2 * ((SQ_BITS + 16 + 1) / 2);
  localparam int SQRT_ITERS = SQRT_IN_BITS / 2;
  localparam int ROOT_BITS  = SQRT_ITERS;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int DEN_BITS   = ROOT_BITS + 1;
  localparam int NUM_BITS   = EXT_BITS + DIFF_BITS + 10;
  localparam int ITER_BITS  = $clog2(NUM_BITS + 1);
  localparam int SUM_BITS   = COORD_BITS + 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_EXTEND = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROOT_X     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROOT_Y     = 2'd2;

  localparam logic FUNC_CLEAR  = 1'b0;
  localparam logic FUNC_EXTEND = 1'b1;

  localparam logic [EXT_BITS-1:0] MAX_EXTEND_RESET = 15'd256;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXT2,
    ST_CHECK,
    ST_SQRT1,
    ST_MULX,
    ST_LDX,
    ST_DIVX,
    ST_MULY,
    ST_LDY,
    ST_DIVY,
    ST_APPLY,
    ST_OFFS,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT2,
    ST_WRITE,
    ST_FINISH
  } state_t;

endpackage

[rtl/core/rrtns_req_if.sv]
// sample / clear request channel
interface rrtns_req_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     func;
  logic signed [rrtns_pkg::COORD_BITS-1:0]  sample_x;
  logic signed [rrtns_pkg::COORD_BITS-1:0]  sample_y;

  modport source(output valid, func, sample_x, sample_y, input ready);
  modport sink(input valid, func, sample_x, sample_y, output ready);
endinterface

[rtl/core/rrtns_rsp_if.sv]
// steered point result channel
interface rrtns_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rrtns_pkg::COORD_BITS-1:0]  new_x;
  logic signed [rrtns_pkg::COORD_BITS-1:0]  new_y;
  logic [rrtns_pkg::IDX_BITS-1:0]           nearest_index;
  logic [rrtns_pkg::IDX_BITS-1:0]           new_index;
  logic [rrtns_pkg::STEP_BITS-1:0]          step_length;
  logic                                     table_full;

  modport source(output valid, new_x, new_y, nearest_index, new_index, step_length,
                 table_full, input ready);
  modport sink(input valid, new_x, new_y, nearest_index, new_index, step_length,
               table_full, output ready);
endinterface

[rtl/core/rrt_nearest_and_steer_core.sv]
// Nearest-point search and steering over a table of tree points. An extend beat
// keeps the sample when it lies within max_extend of its nearest point and steers
// it otherwise; the scan reads one stored point per cycle from the read port of
// the point memory and then drains its pipeline, and a shared bit-serial square
// root (25 steps, run again for the step length) and restoring divider (42 steps
// per axis) do the steering. The root is index 0 and comes from root_x / root_y;
// stored points start at index 1. Results sit in an output register until taken;
// a result still waiting there holds the next one back.
module rrt_nearest_and_steer_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [rrtns_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [rrtns_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  rrtns_req_if.sink                              req,
  rrtns_rsp_if.source                            rsp
);

  localparam int CB = rrtns_pkg::COORD_BITS;
  localparam int DB = rrtns_pkg::DIFF_BITS;
  localparam int MB = rrtns_pkg::MUL_BITS;
  localparam int PB = rrtns_pkg::PROD_BITS;
  localparam int QB = rrtns_pkg::SQ_BITS;
  localparam int RB = rrtns_pkg::ROOT_BITS;
  localparam int NB = rrtns_pkg::NUM_BITS;
  localparam int EB = rrtns_pkg::DEN_BITS;
  localparam int SB = rrtns_pkg::SUM_BITS;
  localparam logic signed [SB-1:0] SAT_MAX = SB'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [SB-1:0] SAT_MIN = SB'(-(64'sd1 <<< (CB - 1)));

  rrtns_pkg::state_t state, state_next;

  // configuration
  logic [rrtns_pkg::EXT_BITS-1:0] max_extend;
  logic signed [CB-1:0]           root_x, root_y;

  // point memory
  logic [2*CB-1:0] point_table [rrtns_pkg::TABLE_DEPTH];
  logic [2*CB-1:0] rd_data;
  logic            wr_en;

  logic [rrtns_pkg::CNT_BITS-1:0] point_count;
  logic [rrtns_pkg::CNT_BITS-1:0] iss;

  // request latch
  logic signed [CB-1:0] sx, sy;

  // scan pipeline
  logic                           s1_v, s2_v, s3_v;
  logic [rrtns_pkg::CNT_BITS-1:0] s1_idx, s2_idx, s3_idx;
  logic signed [DB-1:0]           s2_dx, s2_dy;
  logic signed [CB-1:0]           s2_px, s2_py, s3_px, s3_py;
  logic [QB-1:0]                  s3_sqx, s3_sqy;
  logic signed [CB-1:0]           sel_px, sel_py;
  logic signed [2*DB-1:0]         sqx_full, sqy_full;
  logic [QB-1:0]                  d2;

  logic [QB-1:0]                  best;
  logic [rrtns_pkg::CNT_BITS-1:0] near;
  logic signed [CB-1:0]           nx, ny;
  logic                           scan_done;

  // steering datapath
  logic signed [DB-1:0]   ndx, ndy;
  logic signed [MB-1:0]   mul_a, mul_b;
  logic signed [PB-1:0]   prod;
  logic [QB:0]            sq_acc;
  logic [RB-1:0]          s_root;
  logic [MB-1:0]          qx, qy;
  logic signed [CB-1:0]   px, py;
  logic signed [DB-1:0]   ox, oy;

  // shared square root
  logic [rrtns_pkg::SQRT_IN_BITS-1:0] sq_val;
  logic [rrtns_pkg::REM_BITS-1:0]     sq_rem, sq_rem_sh, sq_trial;
  logic [RB-1:0]                      sq_root, sq_root_next;
  logic                               sq_ge;

  // shared divider
  logic [NB-1:0]                  dv_num;
  logic [EB-1:0]                  dv_den, dv_rem;
  logic [EB:0]                    dv_rem_sh;
  logic                           dv_ge;
  logic [rrtns_pkg::ITER_BITS-1:0] it_cnt;

  // result register
  logic                                rsp_valid;
  logic signed [CB-1:0]                res_x, res_y;
  logic [rrtns_pkg::IDX_BITS-1:0]      res_near, res_new;
  logic [rrtns_pkg::STEP_BITS-1:0]     res_step;
  logic                                res_full;
  logic                                out_load;

  logic                                accept;
  logic signed [SB-1:0]                sum_x, sum_y;

  assign accept = req.valid && req.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_extend <= rrtns_pkg::MAX_EXTEND_RESET;
      root_x     <= '0;
      root_y     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rrtns_pkg::REG_MAX_EXTEND: max_extend <= cfg_data[rrtns_pkg::EXT_BITS-1:0];
        rrtns_pkg::REG_ROOT_X:     root_x     <= cfg_data[CB-1:0];
        rrtns_pkg::REG_ROOT_Y:     root_y     <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // point memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      point_table[point_count[rrtns_pkg::ADDR_BITS-1:0]] <= {py, px};
    end
    rd_data <= point_table[iss[rrtns_pkg::ADDR_BITS-1:0]];
  end

  // scan datapath
  always_comb begin
    if (s1_idx == '0) begin
      sel_px = root_x;
      sel_py = root_y;
    end else begin
      sel_px = rd_data[CB-1:0];
      sel_py = rd_data[2*CB-1:CB];
    end
    sqx_full = s2_dx * s2_dx;
    sqy_full = s2_dy * s2_dy;
    d2 = s3_sqx + s3_sqy;
    scan_done = (iss == point_count) && !s1_v && !s2_v && !s3_v;
  end

  // square root step
  always_comb begin
    sq_rem_sh = {sq_rem[rrtns_pkg::REM_BITS-3:0],
                 sq_val[rrtns_pkg::SQRT_IN_BITS-1 -: 2]};
    sq_trial  = {sq_root, 2'b01};
    sq_ge     = sq_rem_sh >= sq_trial;
    sq_root_next = {sq_root[RB-2:0], sq_ge};
  end

  // divider step
  always_comb begin
    dv_rem_sh = {dv_rem, dv_num[NB-1]};
    dv_ge     = dv_rem_sh >= {1'b0, dv_den};
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      rrtns_pkg::ST_EXT2: begin
        mul_a = MB'(max_extend);
        mul_b = MB'(max_extend);
      end
      rrtns_pkg::ST_MULX: begin
        mul_a = MB'(max_extend);
        mul_b = ndx[DB-1] ? MB'(-ndx) : MB'(ndx);
      end
      rrtns_pkg::ST_MULY: begin
        mul_a = MB'(max_extend);
        mul_b = ndy[DB-1] ? MB'(-ndy) : MB'(ndy);
      end
      rrtns_pkg::ST_SQX: begin
        mul_a = MB'(ox);
        mul_b = MB'(ox);
      end
      rrtns_pkg::ST_SQY: begin
        mul_a = MB'(oy);
        mul_b = MB'(oy);
      end
      default: ;
    endcase
  end

  // steered coordinates before saturation
  always_comb begin
    sum_x = SB'(nx) + (ndx[DB-1] ? -$signed(SB'(qx)) : $signed(SB'(qx)));
    sum_y = SB'(ny) + (ndy[DB-1] ? -$signed(SB'(qy)) : $signed(SB'(qy)));
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrtns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      rrtns_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.func == rrtns_pkg::FUNC_EXTEND) begin
            state_next = rrtns_pkg::ST_SCAN;
          end else begin
            state_next = rrtns_pkg::ST_FINISH;
          end
        end
      end
      rrtns_pkg::ST_SCAN: begin
        if (scan_done) state_next = rrtns_pkg::ST_EXT2;
      end
      rrtns_pkg::ST_EXT2:  state_next = rrtns_pkg::ST_CHECK;
      rrtns_pkg::ST_CHECK: begin
        if (best > QB'(prod)) begin
          state_next = rrtns_pkg::ST_SQRT1;
        end else begin
          state_next = rrtns_pkg::ST_OFFS;
        end
      end
      rrtns_pkg::ST_SQRT1: begin
        if (it_cnt == rrtns_pkg::ITER_BITS'(rrtns_pkg::SQRT_ITERS - 1)) begin
          state_next = rrtns_pkg::ST_MULX;
        end
      end
      rrtns_pkg::ST_MULX: state_next = rrtns_pkg::ST_LDX;
      rrtns_pkg::ST_LDX:  state_next = rrtns_pkg::ST_DIVX;
      rrtns_pkg::ST_DIVX: begin
        if (it_cnt == rrtns_pkg::ITER_BITS'(NB - 1)) state_next = rrtns_pkg::ST_MULY;
      end
      rrtns_pkg::ST_MULY: state_next = rrtns_pkg::ST_LDY;
      rrtns_pkg::ST_LDY:  state_next = rrtns_pkg::ST_DIVY;
      rrtns_pkg::ST_DIVY: begin
        if (it_cnt == rrtns_pkg::ITER_BITS'(NB - 1)) state_next = rrtns_pkg::ST_APPLY;
      end
      rrtns_pkg::ST_APPLY: state_next = rrtns_pkg::ST_OFFS;
      rrtns_pkg::ST_OFFS:  state_next = rrtns_pkg::ST_SQX;
      rrtns_pkg::ST_SQX:   state_next = rrtns_pkg::ST_SQY;
      rrtns_pkg::ST_SQY:   state_next = rrtns_pkg::ST_SUM;
      rrtns_pkg::ST_SUM:   state_next = rrtns_pkg::ST_SQRT2;
      rrtns_pkg::ST_SQRT2: begin
        if (it_cnt == rrtns_pkg::ITER_BITS'(rrtns_pkg::SQRT_ITERS - 1)) begin
          state_next = rrtns_pkg::ST_WRITE;
        end
      end
      rrtns_pkg::ST_WRITE: begin
        wr_en = point_count < rrtns_pkg::CNT_BITS'(rrtns_pkg::TABLE_DEPTH);
        state_next = rrtns_pkg::ST_FINISH;
      end
      rrtns_pkg::ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = rrtns_pkg::ST_IDLE;
        end
      end
      default: state_next = rrtns_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= rrtns_pkg::CNT_BITS'(1);
      iss         <= '0;
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      s3_v        <= 1'b0;
      it_cnt      <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      s2_v <= s1_v;
      s3_v <= s2_v;
      s1_v <= 1'b0;
      if (accept) begin
        iss    <= '0;
        it_cnt <= '0;
        if (req.func == rrtns_pkg::FUNC_CLEAR) point_count <= rrtns_pkg::CNT_BITS'(1);
      end
      if (state == rrtns_pkg::ST_SCAN && iss != point_count) begin
        iss  <= iss + 1'b1;
        s1_v <= 1'b1;
      end
      case (state)
        rrtns_pkg::ST_SQRT1, rrtns_pkg::ST_DIVX, rrtns_pkg::ST_DIVY,
        rrtns_pkg::ST_SQRT2: begin
          if (state_next != state) begin
            it_cnt <= '0;
          end else begin
            it_cnt <= it_cnt + 1'b1;
          end
        end
        default: it_cnt <= '0;
      endcase
      if (wr_en) point_count <= point_count + 1'b1;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (accept) begin
      sx       <= req.sample_x;
      sy       <= req.sample_y;
      res_x    <= '0;
      res_y    <= '0;
      res_near <= '0;
      res_new  <= '0;
      res_step <= '0;
      res_full <= 1'b0;
    end

    if (state == rrtns_pkg::ST_SCAN) begin
      s1_idx <= iss;
    end
    s2_idx <= s1_idx;
    s2_px  <= sel_px;
    s2_py  <= sel_py;
    s2_dx  <= DB'(sx) - DB'(sel_px);
    s2_dy  <= DB'(sy) - DB'(sel_py);
    s3_idx <= s2_idx;
    s3_px  <= s2_px;
    s3_py  <= s2_py;
    s3_sqx <= sqx_full[QB-1:0];
    s3_sqy <= sqy_full[QB-1:0];

    // earlier point wins a tie
    if (s3_v && (s3_idx == '0 || d2 < best)) begin
      best <= d2;
      near <= s3_idx;
      nx   <= s3_px;
      ny   <= s3_py;
    end

    case (state)
      rrtns_pkg::ST_EXT2: begin
        ndx <= DB'(sx) - DB'(nx);
        ndy <= DB'(sy) - DB'(ny);
      end
      rrtns_pkg::ST_CHECK: begin
        px      <= sx;
        py      <= sy;
        sq_val  <= rrtns_pkg::SQRT_IN_BITS'(best) << 16;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      rrtns_pkg::ST_SQRT1, rrtns_pkg::ST_SQRT2: begin
        sq_val  <= sq_val << 2;
        sq_rem  <= sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;
        sq_root <= sq_root_next;
        s_root  <= sq_root_next;
      end
      rrtns_pkg::ST_LDX, rrtns_pkg::ST_LDY: begin
        // 2 * ext * |d| * 256 + s, divided by 2 * s rounds half away
        dv_num <= (NB'(prod[PB-2:0]) << 9) + NB'(s_root);
        dv_den <= {s_root, 1'b0};
        dv_rem <= '0;
      end
      rrtns_pkg::ST_DIVX, rrtns_pkg::ST_DIVY: begin
        dv_num <= {dv_num[NB-2:0], dv_ge};
        dv_rem <= dv_ge ? EB'(dv_rem_sh - {1'b0, dv_den}) : dv_rem_sh[EB-1:0];
        if (state == rrtns_pkg::ST_DIVX) begin
          qx <= {dv_num[MB-2:0], dv_ge};
        end else begin
          qy <= {dv_num[MB-2:0], dv_ge};
        end
      end
      rrtns_pkg::ST_APPLY: begin
        px <= (sum_x > SAT_MAX) ? CB'(SAT_MAX) : (sum_x < SAT_MIN) ? CB'(SAT_MIN) : CB'(sum_x);
        py <= (sum_y > SAT_MAX) ? CB'(SAT_MAX) : (sum_y < SAT_MIN) ? CB'(SAT_MIN) : CB'(sum_y);
      end
      rrtns_pkg::ST_OFFS: begin
        ox <= DB'(px) - DB'(nx);
        oy <= DB'(py) - DB'(ny);
      end
      rrtns_pkg::ST_SQY: begin
        sq_acc <= (QB + 1)'(prod[PB-2:0]);
      end
      rrtns_pkg::ST_SUM: begin
        sq_val  <= rrtns_pkg::SQRT_IN_BITS'(sq_acc + (QB + 1)'(prod[PB-2:0]));
        sq_rem  <= '0;
        sq_root <= '0;
      end
      rrtns_pkg::ST_WRITE: begin
        res_x    <= px;
        res_y    <= py;
        res_near <= rrtns_pkg::IDX_BITS'(near);
        res_step <= s_root[rrtns_pkg::STEP_BITS-1:0];
        if (wr_en) begin
          res_new  <= rrtns_pkg::IDX_BITS'(point_count);
          res_full <= 1'b0;
        end else begin
          res_new  <= '0;
          res_full <= 1'b1;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      rsp.new_x         <= res_x;
      rsp.new_y         <= res_y;
      rsp.nearest_index <= res_near;
      rsp.new_index     <= res_new;
      rsp.step_length   <= res_step;
      rsp.table_full    <= res_full;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule
